FILE: design/ctsc_pkg.sv
// ctsc_pkg: shared types, codes and helpers for the clock time-set controller
`default_nettype none
package ctsc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int DISP_WIDTH  = 18;
  localparam int TOD_WIDTH   = 17;

  // button codes
  localparam logic [2:0] BTN_NONE       = 3'd0;
  localparam logic [2:0] BTN_SET        = 3'd1;
  localparam logic [2:0] BTN_UP         = 3'd2;
  localparam logic [2:0] BTN_DOWN       = 3'd3;
  localparam logic [2:0] BTN_FMT_TOGGLE = 3'd4;
  localparam logic [2:0] BTN_DATE       = 3'd5;

  // op codes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_BUTTON = 1'b1;

  // mode codes
  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_HOURS   = 2'd1;
  localparam logic [1:0] MODE_MINUTES = 2'd2;
  localparam logic [1:0] MODE_SECONDS = 2'd3;

  localparam logic [7:0] LOCKOUT_RESET = 8'd30;

  typedef struct packed {
    logic       op;
    logic [2:0] button;
  } in_item_t;

  typedef struct packed {
    logic [DISP_WIDTH-1:0] display_value;
    logic [1:0]            edit_mode;
    logic                  hour_format_24;
    logic                  afternoon;
    logic                  format_led;
  } out_item_t;

  // 24-hour to 12-hour hours, 0 shows as 12
  function automatic logic [4:0] to_12h(input logic [4:0] h24);
    logic [4:0] h;
    h = h24;
    if (h24 == 5'd0) begin
      h = 5'd12;
    end else if (h24 > 5'd12) begin
      h = h24 - 5'd12;
    end
    return h;
  endfunction

  // 12-hour to 24-hour hours using the kept pm flag
  function automatic logic [4:0] from_12h(input logic [4:0] h12, input logic pm);
    logic [4:0] h;
    h = h12;
    if (!pm) begin
      if (h12 == 5'd12) h = 5'd0;
    end else begin
      if (h12 != 5'd12) h = h12 + 5'd12;
    end
    return h;
  endfunction

  function automatic logic [5:0] wrap_up59(input logic [5:0] v);
    return (v >= 6'd59) ? 6'd0 : v + 6'd1;
  endfunction

  function automatic logic [5:0] wrap_dn59(input logic [5:0] v);
    return (v == 6'd0) ? 6'd59 : v - 6'd1;
  endfunction

endpackage
`default_nettype wire

FILE: design/ctsc_ifs.sv
// ctsc channel interfaces: input items, result items and lockout register writes
`default_nettype none
interface ctsc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [2:0] button;
  modport source (output valid, output op, output button, input ready);
  modport sink   (input valid, input op, input button, output ready);
endinterface

interface ctsc_out_if;
  logic                             valid;
  logic                             ready;
  logic [ctsc_pkg::DISP_WIDTH-1:0]  display_value;
  logic [1:0]                       edit_mode;
  logic                             hour_format_24;
  logic                             afternoon;
  logic                             format_led;
  modport source (output valid, output display_value, output edit_mode,
                  output hour_format_24, output afternoon, output format_led,
                  input ready);
  modport sink   (input valid, input display_value, input edit_mode,
                  input hour_format_24, input afternoon, input format_led,
                  output ready);
endinterface

interface ctsc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] set_lockout_seconds;
  modport source (output valid, output set_lockout_seconds, input ready);
  modport sink   (input valid, input set_lockout_seconds, output ready);
endinterface
`default_nettype wire

FILE: design/clock_time_set_controller.sv
// clock_time_set_controller: seconds counter, time-of-day display and set-mode machine
//
// in_ch carries one beat per event: op 0 is a one-second tick, op 1 a button press
// (button selects set, up, down, format; other codes do nothing). out_ch returns
// exactly one beat per input beat, in order: the HHMMSS display value, the edit
// mode after the beat, the 12/24 format, the kept pm flag and the format led.
// cfg_ch writes the set lockout in seconds; it is always ready and takes effect
// on the next beat processed.
// From input beat to result beat, the beat lands in the input register and the
// update logic fills the result register from it, where the result beat is
// offered. A new beat is taken every cycle while out_ch does not stall; the rate
// is set by the single update pass on the state.
// The time of day is kept as hour/minute/second counters beside the free-running
// seconds counter, so no division sits on the path.
// When the receiver stalls, the result register holds and the input register
// fills; in_ch.ready drops only when both are full.
// Reset (rst_n low, synchronous) clears the counters, edit values and led,
// selects 24-hour form and normal mode, and reloads the lockout with 30.
`default_nettype none
module clock_time_set_controller (
  input  wire logic     clk,
  input  wire logic     rst_n,
  ctsc_in_if.sink       in_ch,
  ctsc_out_if.source    out_ch,
  ctsc_cfg_if.sink      cfg_ch
);

  localparam int CW = ctsc_pkg::COUNT_WIDTH;

  // input register
  logic                 s1_valid_r;
  ctsc_pkg::in_item_t   s1_item_r;

  // state
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        last_set_r, last_set_nxt;
  logic [4:0]           tod_hh_r, tod_hh_nxt;
  logic [5:0]           tod_mm_r, tod_mm_nxt;
  logic [5:0]           tod_ss_r, tod_ss_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic                 use24_r, use24_nxt;
  logic                 pm_r, pm_nxt;
  logic [4:0]           edit_hh_r, edit_hh_nxt;
  logic [5:0]           edit_mm_r, edit_mm_nxt;
  logic [5:0]           edit_ss_r, edit_ss_nxt;
  logic                 led_r, led_nxt;
  logic [7:0]           lockout_r;

  // result register
  logic                 out_valid_r;
  ctsc_pkg::out_item_t  out_item_r, out_item_nxt;

  logic                 advance;
  logic                 commit;
  logic [2:0]           btn;
  logic                 tick;
  logic [CW-1:0]        elapsed;
  logic [4:0]           h12, disp_hh, h24_commit;
  logic [5:0]           disp_mm, disp_ss;
  logic [5:0]           h_up;
  logic [ctsc_pkg::TOD_WIDTH-1:0] now_secs;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.op     <= in_ch.op;
      s1_item_r.button <= in_ch.button;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r <= ctsc_pkg::LOCKOUT_RESET;
    end else if (cfg_ch.valid) begin
      lockout_r <= cfg_ch.set_lockout_seconds;
    end
  end

  assign tick = (s1_item_r.op == ctsc_pkg::OP_TICK);
  assign btn  = tick ? ctsc_pkg::BTN_NONE : s1_item_r.button;

  always_comb begin
    count_nxt    = count_r;
    last_set_nxt = last_set_r;
    tod_hh_nxt   = tod_hh_r;
    tod_mm_nxt   = tod_mm_r;
    tod_ss_nxt   = tod_ss_r;
    mode_nxt     = mode_r;
    use24_nxt    = use24_r;
    pm_nxt       = pm_r;
    edit_hh_nxt  = edit_hh_r;
    edit_mm_nxt  = edit_mm_r;
    edit_ss_nxt  = edit_ss_r;
    led_nxt      = led_r;
    commit       = 1'b0;
    h_up         = 6'd0;
    h24_commit   = 5'd0;
    now_secs     = '0;

    // tick: advance counter and time of day; counter wrap lands on midnight
    if (tick) begin
      count_nxt = count_r + {{(CW-1){1'b0}}, 1'b1};
      if (&count_r) begin
        tod_hh_nxt = 5'd0;
        tod_mm_nxt = 6'd0;
        tod_ss_nxt = 6'd0;
      end else if (tod_ss_r != 6'd59) begin
        tod_ss_nxt = tod_ss_r + 6'd1;
      end else begin
        tod_ss_nxt = 6'd0;
        if (tod_mm_r != 6'd59) begin
          tod_mm_nxt = tod_mm_r + 6'd1;
        end else begin
          tod_mm_nxt = 6'd0;
          tod_hh_nxt = (tod_hh_r >= 5'd23) ? 5'd0 : tod_hh_r + 5'd1;
        end
      end
    end

    elapsed = count_nxt - last_set_r;
    h12     = ctsc_pkg::to_12h(tod_hh_nxt);
    disp_hh = tod_hh_nxt;
    disp_mm = tod_mm_nxt;
    disp_ss = tod_ss_nxt;

    unique case (mode_r)
      ctsc_pkg::MODE_NORMAL: begin
        // pm refresh in 12-hour form or on a format change
        if (!use24_r || btn == ctsc_pkg::BTN_FMT_TOGGLE) begin
          pm_nxt = (tod_hh_nxt >= 5'd12);
        end
        if (btn == ctsc_pkg::BTN_SET &&
            elapsed >= {{(CW-8){1'b0}}, lockout_r}) begin
          last_set_nxt = count_nxt;
          edit_hh_nxt  = use24_r ? tod_hh_nxt : h12;
          edit_mm_nxt  = tod_mm_nxt;
          edit_ss_nxt  = tod_ss_nxt;
          mode_nxt     = ctsc_pkg::MODE_HOURS;
        end
        if (btn == ctsc_pkg::BTN_FMT_TOGGLE) begin
          led_nxt   = !led_r;
          use24_nxt = !use24_r;
        end
        disp_hh = use24_nxt ? tod_hh_nxt : h12;
      end
      ctsc_pkg::MODE_HOURS: begin
        h_up = {1'b0, edit_hh_r} + 6'd1;
        if (btn == ctsc_pkg::BTN_UP) begin
          if (use24_r) edit_hh_nxt = (h_up > 6'd23) ? 5'd0 : h_up[4:0];
          else         edit_hh_nxt = (h_up > 6'd12) ? 5'd1 : h_up[4:0];
        end else if (btn == ctsc_pkg::BTN_DOWN) begin
          if (use24_r) edit_hh_nxt = (edit_hh_r == 5'd0) ? 5'd23 : edit_hh_r - 5'd1;
          else         edit_hh_nxt = (edit_hh_r <= 5'd1) ? 5'd12 : edit_hh_r - 5'd1;
        end else if (btn == ctsc_pkg::BTN_SET) begin
          mode_nxt = ctsc_pkg::MODE_MINUTES;
        end
      end
      ctsc_pkg::MODE_MINUTES: begin
        if (btn == ctsc_pkg::BTN_UP) edit_mm_nxt = ctsc_pkg::wrap_up59(edit_mm_r);
        else if (btn == ctsc_pkg::BTN_DOWN) edit_mm_nxt = ctsc_pkg::wrap_dn59(edit_mm_r);
        else if (btn == ctsc_pkg::BTN_SET) mode_nxt = ctsc_pkg::MODE_SECONDS;
      end
      ctsc_pkg::MODE_SECONDS: begin
        if (btn == ctsc_pkg::BTN_UP) begin
          edit_ss_nxt = ctsc_pkg::wrap_up59(edit_ss_r);
        end else if (btn == ctsc_pkg::BTN_DOWN) begin
          edit_ss_nxt = ctsc_pkg::wrap_dn59(edit_ss_r);
        end else if (btn == ctsc_pkg::BTN_SET) begin
          // commit the edited time of day with the kept pm flag
          commit     = 1'b1;
          h24_commit = use24_r ? edit_hh_r : ctsc_pkg::from_12h(edit_hh_r, pm_r);
          now_secs   = {{(ctsc_pkg::TOD_WIDTH-5){1'b0}}, h24_commit} * 17'd3600
                     + {{(ctsc_pkg::TOD_WIDTH-6){1'b0}}, edit_mm_r} * 17'd60
                     + {{(ctsc_pkg::TOD_WIDTH-6){1'b0}}, edit_ss_r};
          count_nxt    = {{(CW-ctsc_pkg::TOD_WIDTH){1'b0}}, now_secs};
          last_set_nxt = {{(CW-ctsc_pkg::TOD_WIDTH){1'b0}}, now_secs};
          tod_hh_nxt   = h24_commit;
          tod_mm_nxt   = edit_mm_r;
          tod_ss_nxt   = edit_ss_r;
          mode_nxt     = ctsc_pkg::MODE_NORMAL;
        end
      end
      default: begin
        mode_nxt = ctsc_pkg::MODE_NORMAL;
      end
    endcase

    if (mode_r != ctsc_pkg::MODE_NORMAL) begin
      disp_hh = edit_hh_nxt;
      disp_mm = edit_mm_nxt;
      disp_ss = edit_ss_nxt;
    end

    out_item_nxt.display_value =
        {{(ctsc_pkg::DISP_WIDTH-5){1'b0}}, disp_hh} * 18'd10000
      + {{(ctsc_pkg::DISP_WIDTH-6){1'b0}}, disp_mm} * 18'd100
      + {{(ctsc_pkg::DISP_WIDTH-6){1'b0}}, disp_ss};
    out_item_nxt.edit_mode      = mode_nxt;
    out_item_nxt.hour_format_24 = use24_nxt;
    out_item_nxt.afternoon      = pm_nxt;
    out_item_nxt.format_led     = led_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      last_set_r <= '0;
      tod_hh_r   <= 5'd0;
      tod_mm_r   <= 6'd0;
      tod_ss_r   <= 6'd0;
      mode_r     <= ctsc_pkg::MODE_NORMAL;
      use24_r    <= 1'b1;
      pm_r       <= 1'b0;
      edit_hh_r  <= 5'd0;
      edit_mm_r  <= 6'd0;
      edit_ss_r  <= 6'd0;
      led_r      <= 1'b0;
    end else if (advance) begin
      count_r    <= count_nxt;
      last_set_r <= last_set_nxt;
      tod_hh_r   <= tod_hh_nxt;
      tod_mm_r   <= tod_mm_nxt;
      tod_ss_r   <= tod_ss_nxt;
      mode_r     <= mode_nxt;
      use24_r    <= use24_nxt;
      pm_r       <= pm_nxt;
      edit_hh_r  <= edit_hh_nxt;
      edit_mm_r  <= edit_mm_nxt;
      edit_ss_r  <= edit_ss_nxt;
      led_r      <= led_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.display_value  = out_item_r.display_value;
  assign out_ch.edit_mode      = out_item_r.edit_mode;
  assign out_ch.hour_format_24 = out_item_r.hour_format_24;
  assign out_ch.afternoon      = out_item_r.afternoon;
  assign out_ch.format_led     = out_item_r.format_led;

  // time of day counters stay in range
  a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
    tod_hh_r <= 5'd23 && tod_mm_r <= 6'd59 && tod_ss_r <= 6'd59)
    else $error("time of day out of range");

  // edit hours stay legal for the format while editing
  a_edit_hours: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != ctsc_pkg::MODE_NORMAL) |->
      (use24_r ? (edit_hh_r <= 5'd23) : (edit_hh_r >= 5'd1 && edit_hh_r <= 5'd12)))
    else $error("edit hours out of range");

  // input stalls only when both registers are full and the sink holds off
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without cause");

  // a commit leaves counter and last-set mark equal, back in normal mode
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && commit) |=>
      (count_r == last_set_r && mode_r == ctsc_pkg::MODE_NORMAL))
    else $error("commit did not load counter");

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// tb: self-checking testbench for the clock time-set controller, random and directed beats
`timescale 1ns / 100ps
module tb;

  localparam int          HALF_PERIOD = 5;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          DRAIN_WAIT  = 6;
  localparam int          CW          = ctsc_pkg::COUNT_WIDTH;
  localparam int          DW          = ctsc_pkg::DISP_WIDTH;
  localparam int unsigned DAY_SECS    = 86400;
  localparam int unsigned HOUR_SECS   = 3600;
  localparam logic [2:0]  BTN_SPARE6  = 3'd6;
  localparam logic [2:0]  BTN_SPARE7  = 3'd7;

  logic clk;
  logic rst_n;

  ctsc_in_if  in_ch();
  ctsc_out_if out_ch();
  ctsc_cfg_if cfg_ch();

  clock_time_set_controller i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // pending beats and expected displays
  ctsc_pkg::in_item_t  pending_q[$];
  ctsc_pkg::out_item_t expected_q[$];

  // predicted clock state
  logic [CW-1:0]          sec_count;
  logic [CW-1:0]          last_set;
  logic [1:0]             clk_mode;
  logic                   fmt_24;
  logic                   pm_state;
  logic                   led;
  logic [4:0]             edit_h;
  logic [5:0]             edit_m;
  logic [5:0]             edit_s;
  logic [7:0]             lockout;

  int errors;
  int beats_in;
  int beats_out;
  int sets_started;
  int commits;
  int lockout_writes;
  int cycle_count;

  logic                in_took;
  ctsc_pkg::in_item_t  drive_beat;
  ctsc_pkg::in_item_t  seen_beat;
  ctsc_pkg::out_item_t want;
  ctsc_pkg::out_item_t got;
  int                  burst_left;
  int                  gap_left;
  logic                rx_ready;
  int                  rx_left;

  always #HALF_PERIOD clk = ~clk;

  // hours to 12-hour form, refreshing the pm flag
  function automatic logic [4:0] hour_to_12(input logic [4:0] h);
    pm_state = (h >= 5'd12);
    if (h == 5'd0) return 5'd12;
    if (h > 5'd12) return h - 5'd12;
    return h;
  endfunction

  function automatic logic [4:0] hour_to_24(input logic [4:0] h);
    if (!pm_state) return (h == 5'd12) ? 5'd0 : h;
    return (h != 5'd12) ? h + 5'd12 : h;
  endfunction

  function automatic ctsc_pkg::out_item_t advance_clock(input ctsc_pkg::in_item_t it);
    logic [2:0]          btn;
    int unsigned         tod;
    int unsigned         disp;
    logic [4:0]          hh;
    logic [5:0]          mm;
    logic [5:0]          ss;
    logic [4:0]          h24;
    ctsc_pkg::out_item_t r;
    btn = (it.op == ctsc_pkg::OP_BUTTON) ? it.button : ctsc_pkg::BTN_NONE;
    if (it.op == ctsc_pkg::OP_TICK) sec_count = sec_count + CW'(1);
    if (clk_mode == ctsc_pkg::MODE_NORMAL) begin
      tod = sec_count % DAY_SECS;
      hh = 5'(tod / HOUR_SECS);
      mm = 6'((tod % HOUR_SECS) / 60);
      ss = 6'(tod % 60);
      if (!fmt_24) hh = hour_to_12(hh);
      if (btn == ctsc_pkg::BTN_SET && CW'(sec_count - last_set) >= lockout) begin
        last_set = sec_count;
        edit_h = hh;
        edit_m = mm;
        edit_s = ss;
        clk_mode = ctsc_pkg::MODE_HOURS;
        sets_started++;
      end
      if (btn == ctsc_pkg::BTN_FMT_TOGGLE) begin
        led = ~led;
        if (fmt_24) begin
          fmt_24 = 1'b0;
          hh = hour_to_12(hh);
        end else begin
          fmt_24 = 1'b1;
          hh = hour_to_24(hh);
        end
      end
    end else begin
      case (clk_mode)
        ctsc_pkg::MODE_HOURS: begin
          if (btn == ctsc_pkg::BTN_UP) begin
            edit_h = edit_h + 5'd1;
            if (fmt_24 && edit_h > 5'd23) edit_h = 5'd0;
            if (!fmt_24 && edit_h > 5'd12) edit_h = 5'd1;
          end else if (btn == ctsc_pkg::BTN_DOWN) begin
            if (fmt_24) edit_h = (edit_h == 5'd0) ? 5'd23 : edit_h - 5'd1;
            else edit_h = (edit_h <= 5'd1) ? 5'd12 : edit_h - 5'd1;
          end else if (btn == ctsc_pkg::BTN_SET) begin
            clk_mode = ctsc_pkg::MODE_MINUTES;
          end
        end
        ctsc_pkg::MODE_MINUTES: begin
          if (btn == ctsc_pkg::BTN_UP) edit_m = (edit_m >= 6'd59) ? 6'd0 : edit_m + 6'd1;
          else if (btn == ctsc_pkg::BTN_DOWN) edit_m = (edit_m == 6'd0) ? 6'd59 : edit_m - 6'd1;
          else if (btn == ctsc_pkg::BTN_SET) clk_mode = ctsc_pkg::MODE_SECONDS;
        end
        default: begin
          if (btn == ctsc_pkg::BTN_UP) edit_s = (edit_s >= 6'd59) ? 6'd0 : edit_s + 6'd1;
          else if (btn == ctsc_pkg::BTN_DOWN) edit_s = (edit_s == 6'd0) ? 6'd59 : edit_s - 6'd1;
          else if (btn == ctsc_pkg::BTN_SET) begin
            // commit uses the pm flag kept from before editing
            h24 = fmt_24 ? edit_h : hour_to_24(edit_h);
            sec_count = CW'(h24 * HOUR_SECS + edit_m * 60 + edit_s);
            last_set = sec_count;
            clk_mode = ctsc_pkg::MODE_NORMAL;
            commits++;
          end
        end
      endcase
      hh = edit_h;
      mm = edit_m;
      ss = edit_s;
    end
    disp = hh * 10000 + mm * 100 + ss;
    r.display_value  = DW'(disp);
    r.edit_mode      = clk_mode;
    r.hour_format_24 = fmt_24;
    r.afternoon      = pm_state;
    r.format_led     = led;
    return r;
  endfunction

  function automatic void queue_beat(input logic op, input logic [2:0] btn);
    ctsc_pkg::in_item_t b;
    b.op = op;
    b.button = btn;
    pending_q.push_back(b);
  endfunction

  task automatic report_field(input string name, input logic [31:0] e, input logic [31:0] a);
    $display("%0t: %s expected %0d got %0d", $time, name, e, a);
    errors++;
  endtask

  // sender in bursts, receiver on its own stall pattern
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_took)) begin
      if (gap_left > 0 || pending_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        drive_beat = pending_q.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.op     <= drive_beat.op;
        in_ch.button <= drive_beat.button;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
    if (rx_left > 0) begin
      rx_left--;
    end else if (rx_ready && $urandom_range(0, 2) != 0) begin
      rx_ready = 1'b0;
      rx_left = $urandom_range(0, 7);
    end else begin
      rx_ready = 1'b1;
      rx_left = $urandom_range(1, 24);
    end
    out_ch.ready <= rx_ready;
  end

  // predict on accepted input beats, check accepted output beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        seen_beat.op = in_ch.op;
        seen_beat.button = in_ch.button;
        expected_q.push_back(advance_clock(seen_beat));
        beats_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        beats_out++;
        got.display_value  = out_ch.display_value;
        got.edit_mode      = out_ch.edit_mode;
        got.hour_format_24 = out_ch.hour_format_24;
        got.afternoon      = out_ch.afternoon;
        got.format_led     = out_ch.format_led;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected output beat, expected none got display %0d",
                   $time, got.display_value);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.display_value !== want.display_value)
            report_field("display_value", 32'(want.display_value), 32'(got.display_value));
          if (got.edit_mode !== want.edit_mode)
            report_field("edit_mode", 32'(want.edit_mode), 32'(got.edit_mode));
          if (got.hour_format_24 !== want.hour_format_24)
            report_field("hour_format_24", 32'(want.hour_format_24),
                         32'(got.hour_format_24));
          if (got.afternoon !== want.afternoon)
            report_field("afternoon", 32'(want.afternoon), 32'(got.afternoon));
          if (got.format_led !== want.format_led)
            report_field("format_led", 32'(want.format_led), 32'(got.format_led));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats still expected", $time, expected_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_ch.valid || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_lockout(input logic [7:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.set_lockout_seconds <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    lockout = v;
    lockout_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic queue_random(input int n);
    int kind;
    int fields;
    int presses;
    int sel;
    while (pending_q.size() < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // edit session, sometimes cut short
        fields = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 3;
        queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_SET);
        repeat (fields) begin
          presses = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 65) : $urandom_range(0, 8);
          repeat (presses) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_UP);
            else if (sel < 8) queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_DOWN);
            else if (sel == 8) queue_beat(ctsc_pkg::OP_TICK, 3'($urandom_range(0, 7)));
            else queue_beat(ctsc_pkg::OP_BUTTON, 3'($urandom_range(0, 7)));
          end
          queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_SET);
        end
      end else if (kind < 88) begin
        repeat ($urandom_range(1, lockout + 5))
          queue_beat(ctsc_pkg::OP_TICK, 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 2) == 0)
          queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_FMT_TOGGLE);
      end else begin
        repeat ($urandom_range(1, 4))
          queue_beat(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = ctsc_pkg::OP_TICK;
    in_ch.button = ctsc_pkg::BTN_NONE;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.set_lockout_seconds = ctsc_pkg::LOCKOUT_RESET;
    in_took = 1'b0;
    burst_left = 0;
    gap_left = 0;
    rx_ready = 1'b0;
    rx_left = 0;
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    sets_started = 0;
    commits = 0;
    lockout_writes = 0;
    cycle_count = 0;
    sec_count = '0;
    last_set = '0;
    clk_mode = ctsc_pkg::MODE_NORMAL;
    fmt_24 = 1'b1;
    pm_state = 1'b0;
    led = 1'b0;
    edit_h = '0;
    edit_m = '0;
    edit_s = '0;
    lockout = ctsc_pkg::LOCKOUT_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // lockout still running, unused buttons, format round trip
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_SET);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_NONE);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_DATE);
    queue_beat(ctsc_pkg::OP_BUTTON, BTN_SPARE6);
    queue_beat(ctsc_pkg::OP_BUTTON, BTN_SPARE7);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_FMT_TOGGLE);
    queue_beat(ctsc_pkg::OP_TICK, BTN_SPARE7);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_FMT_TOGGLE);
    wait_idle();
    write_lockout(8'd0);

    // set 23:59:00 through the hour and minute wraps, format ignored while editing, then a tick
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_SET);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_DOWN);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_UP);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_DOWN);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_SET);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_DOWN);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_SET);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_DOWN);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_FMT_TOGGLE);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_SET);
    queue_beat(ctsc_pkg::OP_TICK, ctsc_pkg::BTN_NONE);
    // 12-hour edit: hour steps 11 -> 10 -> 11 -> 12, commit as pm
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_FMT_TOGGLE);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_SET);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_DOWN);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_UP);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_UP);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_SET);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_SET);
    queue_beat(ctsc_pkg::OP_BUTTON, ctsc_pkg::BTN_SET);
    wait_idle();

    queue_random(200);
    wait_idle();
    write_lockout(8'($urandom_range(1, 254)));
    queue_random(200);
    wait_idle();
    write_lockout(8'd255);
    queue_random(200);
    wait_idle();

    $display("covered %0d beats in, %0d beats out, %0d edits started, %0d times committed",
             beats_in, beats_out, sets_started, commits);
    $display("lockout written %0d times, last value %0d", lockout_writes, lockout);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0t: %0d mismatches, %0d beats never arrived", $time, errors, expected_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ctsc_pkg.sv
design/ctsc_ifs.sv
design/clock_time_set_controller.sv
tb/sv/tb.sv
